>>> hdl/assert_macros.svh
// assertion helpers included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define APSDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// checked on every edge, reset included
`define APSDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/apsdc_pkg.sv
package apsdc_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned ThetaW    = 8;
  localparam int unsigned KW        = 8;
  localparam int unsigned ProdW     = DataW + KW;
  localparam int unsigned ThrW      = DataW + ThetaW + 1;
  localparam int unsigned CntW      = $clog2(DataW);
  localparam int unsigned CfgAw     = 3;
  localparam int unsigned CfgDw     = 32;
  localparam int unsigned RegIdxLsb = 2;

  localparam logic [ThetaW-1:0] THETA_RST = 8'd26;
  localparam logic [KW-1:0]     KDIV_RST  = 8'd4;

  // register indexes
  localparam logic REG_THETA = 1'b0;
  localparam logic REG_KDIV  = 1'b1;

  typedef enum logic [2:0] {
    DEC_IGNORED   = 3'd0,
    DEC_DECREASED = 3'd1,
    DEC_INCREASED = 3'd2,
    DEC_UNCHANGED = 3'd3,
    DEC_LOADED    = 3'd4
  } decision_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WIN,
    S_CLASS,
    S_PREP_DEN,
    S_PREP_MC,
    S_MUL,
    S_DIV,
    S_OUT
  } state_t;

endpackage

>>> hdl/apsdc_in_if.sv
interface apsdc_in_if import apsdc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             action;
  logic             is_ack;
  logic [DataW-1:0] ack_number;
  logic [DataW-1:0] oldest_unacked;
  logic [DataW-1:0] highest_sent;
  logic [DataW-1:0] delay_value;

  modport source (output valid, action, is_ack, ack_number, oldest_unacked,
                  highest_sent, delay_value, input ready);
  modport sink   (input valid, action, is_ack, ack_number, oldest_unacked,
                  highest_sent, delay_value, output ready);
endinterface

>>> hdl/apsdc_out_if.sv
interface apsdc_out_if import apsdc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] send_delay;
  decision_t        decision;

  modport source (output valid, send_delay, decision, input ready);
  modport sink   (input valid, send_delay, decision, output ready);
endinterface

>>> hdl/ack_paced_send_delay_control_top.sv
// ack-paced send delay control: holds the current inter-packet send delay (us) and returns
// one word per input word with the delay after that word and a decision code. an enter word
// (action 0) loads delay_value; a packet word is ignored unless it is an ack whose number lies
// in (oldest_unacked, highest_sent] in modular 32-bit sequence space; a larger reported delay
// is taken as is; a current delay above reported*(1+theta_q8/256) moves 1/K of the rate gap
// toward the reported rate, delay = floor(K*cur*new / ((K-1)*new + cur)), K = 0 read as 1.
// one word is in flight at a time. enter, ignored, decreased and unchanged words go from
// accept to result through the win, class and out states; an increased word also visits
// prep_den, prep_mc, the radix-2 shift-add multiplier (cur * K*new) and the radix-2
// restoring divider (the 72-bit numerator over the 40-bit denominator) that share one shift
// register pair. a new word is accepted as soon as the result sits in the output register,
// even if not yet taken. config registers over apb: theta_q8 at 0x0 (reset 26),
// smoothing_divisor at 0x4 (reset 4); write them only while the block is idle.
`include "assert_macros.svh"

module ack_paced_send_delay_control_top import apsdc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  apsdc_in_if.sink         in_ch,
  apsdc_out_if.source      out_ch,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [CfgAw-1:0] cfg_paddr,
  input  logic [CfgDw-1:0] cfg_pwdata,
  output logic [CfgDw-1:0] cfg_prdata,
  output logic             cfg_pready
);

  // control state
  state_t            state_r, state_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;

  // architectural state and config
  logic [DataW-1:0]  cur_r, cur_nxt;
  logic [ThetaW-1:0] theta_r;
  logic [KW-1:0]     kdiv_r;

  // captured input word
  logic              action_r, is_ack_r;
  logic [DataW-1:0]  ack_r, una_r, hs_r, nw_r;

  // working registers
  logic [DataW-1:0]  off_r, off_nxt;
  logic [DataW-1:0]  span_r, span_nxt;
  logic              gt_r, gt_nxt;
  logic [ProdW-1:0]  thr_r, thr_nxt;
  logic [ProdW-1:0]  den_r, den_nxt;
  logic [ProdW-1:0]  mc_r, mc_nxt;
  logic [ProdW-1:0]  hi_r, hi_nxt;
  logic [DataW-1:0]  lo_r, lo_nxt;
  logic [DataW-1:0]  res_r, res_nxt;
  decision_t         dec_r, dec_nxt;

  // output register
  logic [DataW-1:0]  out_delay_r;
  decision_t         out_dec_r;

  logic              in_take;
  logic              out_load;
  logic              cfg_wr;
  logic [KW-1:0]     k_eff;
  logic [KW-1:0]     mul_op;
  logic [ProdW-1:0]  mul_p;
  logic [ProdW:0]    add_sum;
  logic [ProdW:0]    trial;
  logic [ProdW:0]    diff;
  logic              qbit;
  logic              win_ok;
  logic [ThrW-1:0]   thr_lhs, thr_rhs;
  logic              cnt_last;

  // ---------------------------------------------------------------------------
  // apb config port
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      theta_r <= THETA_RST;
      kdiv_r  <= KDIV_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[RegIdxLsb])
        REG_THETA: theta_r <= cfg_pwdata[ThetaW-1:0];
        REG_KDIV:  kdiv_r  <= cfg_pwdata[KW-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[RegIdxLsb])
      REG_THETA: cfg_prdata = {{(CfgDw-ThetaW){1'b0}}, theta_r};
      REG_KDIV:  cfg_prdata = {{(CfgDw-KW){1'b0}}, kdiv_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // shared datapath
  // ---------------------------------------------------------------------------
  // a smoothing divisor of zero behaves as one
  assign k_eff = (kdiv_r == '0) ? KW'(1) : kdiv_r;

  // one narrow multiplier: new*theta, new*(K-1), new*K in the win, prep_den and prep_mc states
  always_comb begin
    case (state_r)
      S_PREP_DEN: mul_op = k_eff - KW'(1);
      S_PREP_MC:  mul_op = k_eff;
      default:    mul_op = theta_r;
    endcase
  end
  assign mul_p = {{KW{1'b0}}, nw_r} * {{DataW{1'b0}}, mul_op};

  // shift-add step, multiplier bits from lo, lsb first
  assign add_sum = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mc_r} : '0);

  // restoring divide step; hi stays below den so trial fits
  assign trial = {hi_r, lo_r[DataW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign qbit  = ~diff[ProdW];

  // modular sequence window (oldest_unacked, highest_sent]
  assign win_ok = is_ack_r && (off_r != '0) && (off_r <= span_r);

  // cur*256 against new*(256+theta)
  assign thr_lhs = {1'b0, cur_r, {ThetaW{1'b0}}};
  assign thr_rhs = {1'b0, nw_r, {ThetaW{1'b0}}} + {1'b0, thr_r};

  assign cnt_last = (cnt_r == CntW'(DataW - 1));

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign in_take  = in_ch.valid & in_ch.ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      cur_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      cur_r       <= cur_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      action_r <= in_ch.action;
      is_ack_r <= in_ch.is_ack;
      ack_r    <= in_ch.ack_number;
      una_r    <= in_ch.oldest_unacked;
      hs_r     <= in_ch.highest_sent;
      nw_r     <= in_ch.delay_value;
    end
    off_r  <= off_nxt;
    span_r <= span_nxt;
    gt_r   <= gt_nxt;
    thr_r  <= thr_nxt;
    den_r  <= den_nxt;
    mc_r   <= mc_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
    res_r  <= res_nxt;
    dec_r  <= dec_nxt;
    if (out_load) begin
      out_delay_r <= res_r;
      out_dec_r   <= dec_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cur_nxt     = cur_r;
    off_nxt     = off_r;
    span_nxt    = span_r;
    gt_nxt      = gt_r;
    thr_nxt     = thr_r;
    den_nxt     = den_r;
    mc_nxt      = mc_r;
    hi_nxt      = hi_r;
    lo_nxt      = lo_r;
    res_nxt     = res_r;
    dec_nxt     = dec_r;
    in_ch.ready = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) state_nxt = S_WIN;
      end
      S_WIN: begin
        off_nxt   = ack_r - una_r;
        span_nxt  = hs_r - una_r;
        gt_nxt    = nw_r > cur_r;
        thr_nxt   = mul_p;
        state_nxt = S_CLASS;
      end
      S_CLASS: begin
        state_nxt = S_OUT;
        if (!action_r) begin
          res_nxt = nw_r;
          dec_nxt = DEC_LOADED;
        end else if (!win_ok) begin
          res_nxt = cur_r;
          dec_nxt = DEC_IGNORED;
        end else if (gt_r) begin
          res_nxt = nw_r;
          dec_nxt = DEC_DECREASED;
        end else if (thr_lhs > thr_rhs) begin
          state_nxt = S_PREP_DEN;
        end else begin
          res_nxt = cur_r;
          dec_nxt = DEC_UNCHANGED;
        end
      end
      S_PREP_DEN: begin
        // (K-1)*new + cur stays below 2^40
        den_nxt   = mul_p + {{KW{1'b0}}, cur_r};
        state_nxt = S_PREP_MC;
      end
      S_PREP_MC: begin
        mc_nxt    = mul_p;
        hi_nxt    = '0;
        lo_nxt    = cur_r;
        cnt_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        hi_nxt  = add_sum[ProdW:1];
        lo_nxt  = {add_sum[0], lo_r[DataW-1:1]};
        cnt_nxt = cnt_r + CntW'(1);
        if (cnt_last) state_nxt = S_DIV;
      end
      S_DIV: begin
        hi_nxt  = qbit ? diff[ProdW-1:0] : trial[ProdW-1:0];
        lo_nxt  = {lo_r[DataW-2:0], qbit};
        cnt_nxt = cnt_r + CntW'(1);
        if (cnt_last) begin
          res_nxt   = {lo_r[DataW-2:0], qbit};
          dec_nxt   = DEC_INCREASED;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          cur_nxt   = res_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register: holds the word until taken
  always_comb begin
    if (out_load)          out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.send_delay = out_delay_r;
  assign out_ch.decision   = out_dec_r;

  // ---------------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------------
  `APSDC_ASSERT(a_div_rem_bound, (state_r == S_DIV) |-> (hi_r < den_r), "divider remainder overflow")
  `APSDC_ASSERT(a_inc_range, (out_load && dec_r == DEC_INCREASED) |-> (res_r >= nw_r && res_r < cur_r), "increased delay out of range")
  `APSDC_ASSERT(a_dec_grows, (out_load && dec_r == DEC_DECREASED) |-> (res_r > cur_r), "decreased rate without larger delay")
  `APSDC_ASSERT(a_cur_hold, (!out_load) |=> $stable(cur_r), "delay changed without a result")
  `APSDC_ASSERT_ALWAYS(a_rst_out, (!rst_n) |=> (!out_valid_r && state_r == S_IDLE), "reset left work pending")

endmodule

>>> dv/ack_paced_send_delay_control_top_tb.sv
`timescale 1ns / 100ps

module ack_paced_send_delay_control_top_tb;
  import apsdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned SETTLE_CYCLES = 8;

  // one input word as the block sees it
  typedef struct packed {
    logic             action;
    logic             is_ack;
    logic [DataW-1:0] ack_number;
    logic [DataW-1:0] oldest_unacked;
    logic [DataW-1:0] highest_sent;
    logic [DataW-1:0] delay_value;
  } in_word_t;

  // one result word the block should return
  typedef struct packed {
    logic [DataW-1:0] send_delay;
    decision_t        decision;
  } delay_result_t;

  // tracks the send delay and the registers, holds the results still due
  class send_delay_checker;
    logic [ThetaW-1:0] theta;
    logic [KW-1:0]     kdiv;
    logic [DataW-1:0]  cur_delay;
    delay_result_t     delays_due[$];
    int                mismatches;

    function new();
      theta      = THETA_RST;
      kdiv       = KDIV_RST;
      cur_delay  = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [7:0] val);
      if (idx == REG_THETA) theta = val;
      else kdiv = val;
    endfunction

    // update the delay for an accepted word and queue the result it causes
    function decision_t take_word(in_word_t w);
      logic [DataW-1:0] off;
      logic [DataW-1:0] span;
      logic [47:0]      scaled_cur;
      logic [47:0]      thr;
      logic [79:0]      num;
      logic [79:0]      den;
      logic [KW-1:0]    k;
      decision_t        dec;
      delay_result_t    res;
      off  = w.ack_number - w.oldest_unacked;
      span = w.highest_sent - w.oldest_unacked;
      if (!w.action) begin
        cur_delay = w.delay_value;
        dec = DEC_LOADED;
      end else if (!w.is_ack || off == '0 || off > span) begin
        dec = DEC_IGNORED;
      end else if (w.delay_value > cur_delay) begin
        cur_delay = w.delay_value;
        dec = DEC_DECREASED;
      end else begin
        scaled_cur = {8'd0, cur_delay, 8'd0};
        thr = 48'(w.delay_value) * (48'd256 + 48'(theta));
        if (scaled_cur > thr) begin
          // close 1/K of the rate gap, exact in wide integers
          k = (kdiv == '0) ? KW'(1) : kdiv;
          num = 80'(k) * 80'(cur_delay) * 80'(w.delay_value);
          den = 80'(k - KW'(1)) * 80'(w.delay_value) + 80'(cur_delay);
          cur_delay = DataW'(num / den);
          dec = DEC_INCREASED;
        end else begin
          dec = DEC_UNCHANGED;
        end
      end
      res.send_delay = cur_delay;
      res.decision   = dec;
      delays_due.push_back(res);
      return dec;
    endfunction

    function void check_result(logic [DataW-1:0] got_delay, decision_t got_dec);
      delay_result_t want;
      if (delays_due.size() == 0) begin
        $display("%0t: unexpected result delay=%0d decision=%0d", $time, got_delay, got_dec);
        mismatches++;
        return;
      end
      want = delays_due.pop_front();
      if (got_delay !== want.send_delay) begin
        $display("%0t: send_delay expected %0d actual %0d", $time, want.send_delay, got_delay);
        mismatches++;
      end
      if (got_dec !== want.decision) begin
        $display("%0t: decision expected %0d actual %0d", $time, want.decision, got_dec);
        mismatches++;
      end
    endfunction

    function int pending();
      return delays_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic             cfg_psel;
  logic             cfg_penable;
  logic             cfg_pwrite;
  logic [CfgAw-1:0] cfg_paddr;
  logic [CfgDw-1:0] cfg_pwdata;
  logic [CfgDw-1:0] cfg_prdata;
  logic             cfg_pready;

  apsdc_in_if  in_if ();
  apsdc_out_if out_if ();

  send_delay_checker sb = new();

  bit          stall_free;    // result side takes every word at once
  bit          in_gaps_on;    // sender leaves gaps between words
  int unsigned hold_cnt = 0;
  int unsigned cycles = 0;

  ack_paced_send_delay_control_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // run guard: a hung block ends here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side back-pressure
  always @(posedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt     <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else if (!stall_free && $urandom_range(0, 9) == 0) begin
      hold_cnt     <= pick_gap();
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // every word taken by the result side is checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.send_delay, out_if.decision);
  end

  function automatic in_word_t mk_word(logic act, logic ack_f, logic [DataW-1:0] ackn,
                                       logic [DataW-1:0] una, logic [DataW-1:0] hs,
                                       logic [DataW-1:0] dly);
    in_word_t w;
    w.action         = act;
    w.is_ack         = ack_f;
    w.ack_number     = ackn;
    w.oldest_unacked = una;
    w.highest_sent   = hs;
    w.delay_value    = dly;
    return w;
  endfunction

  // offer one word, wait for the accept, then maybe leave a gap
  // called right after a rising edge; valid stays high across back-to-back words
  task automatic send_word(input in_word_t w, output decision_t dec);
    int unsigned gap;
    in_if.valid          <= 1'b1;
    in_if.action         <= w.action;
    in_if.is_ack         <= w.is_ack;
    in_if.ack_number     <= w.ack_number;
    in_if.oldest_unacked <= w.oldest_unacked;
    in_if.highest_sent   <= w.highest_sent;
    in_if.delay_value    <= w.delay_value;
    do @(posedge clk); while (!in_if.ready);
    dec = sb.take_word(w);
    gap = in_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid and wait until the block has handed back every result
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(input logic idx, input logic [7:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CfgAw'(idx) << RegIdxLsb;
    cfg_pwdata  <= CfgDw'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // one register setting, then random words until enough non-ignored ones were taken
  task automatic run_phase(input logic [7:0] theta, input logic [7:0] kdiv,
                           input int unsigned n_words, input bit calm);
    in_word_t         w;
    decision_t        dec;
    int unsigned      taken;
    int unsigned      sent;
    int unsigned      r;
    logic [DataW-1:0] span;
    logic [DataW-1:0] cur;
    logic [63:0]      thr;
    settle();
    write_reg(REG_THETA, theta);
    write_reg(REG_KDIV, kdiv);
    stall_free = calm;
    in_gaps_on = !calm;
    taken = 0;
    sent  = 0;
    while (taken < n_words) begin
      // stretches with and without sender gaps
      if (!calm && sent % 50 == 0) in_gaps_on = ($urandom_range(0, 2) != 0);
      cur = sb.cur_delay;
      r = $urandom_range(0, 99);
      // well-formed ack in a random window
      w.action         = (r >= 7);
      w.is_ack         = 1'b1;
      w.oldest_unacked = $urandom;
      span = ($urandom_range(0, 3) == 0) ? DataW'($urandom) : DataW'($urandom_range(1, 5000));
      if (span == '0) span = 1;
      w.highest_sent = w.oldest_unacked + span;
      w.ack_number   = w.oldest_unacked + 1 + ($urandom % span);
      if (!w.action) begin
        w.is_ack = 1'($urandom_range(0, 1));
        w.delay_value = ($urandom_range(0, 3) == 0) ? DataW'($urandom)
                                                    : DataW'($urandom_range(0, 100000));
      end else begin
        // noise: non-ack, ack at the window floor, past the top, anywhere
        if (r >= 88) begin
          case ($urandom_range(0, 3))
            0: begin
              w.is_ack = 1'b0;
              w.ack_number = $urandom;
            end
            1: w.ack_number = w.oldest_unacked;
            2: w.ack_number = w.highest_sent + 1 + $urandom_range(0, 100);
            default: w.ack_number = $urandom;
          endcase
        end
        case ($urandom_range(0, 9))
          0: w.delay_value = $urandom;
          1: w.delay_value = '0;
          2: w.delay_value = cur + 1 + $urandom_range(0, 1000);
          3: w.delay_value = cur;
          4, 5: begin
            // straddle the increase threshold
            thr = ({32'd0, cur} * 64'd256) / (64'd256 + 64'(theta));
            w.delay_value = DataW'(thr) + $urandom_range(0, 2) - 1;
          end
          6, 7: w.delay_value = cur >> $urandom_range(1, 8);
          default: w.delay_value = cur - DataW'({32'd0, $urandom} % ({32'd0, cur} + 64'd1));
        endcase
      end
      send_word(w, dec);
      sent++;
      if (dec != DEC_IGNORED) taken++;
    end
  endtask

  initial begin
    decision_t dec;
    // every input but the result-side ready known from time zero
    rst_n                <= 1'b0;
    in_if.valid          <= 1'b0;
    in_if.action         <= 1'b0;
    in_if.is_ack         <= 1'b0;
    in_if.ack_number     <= '0;
    in_if.oldest_unacked <= '0;
    in_if.highest_sent   <= '0;
    in_if.delay_value    <= '0;
    cfg_psel             <= 1'b0;
    cfg_penable          <= 1'b0;
    cfg_pwrite           <= 1'b0;
    cfg_paddr            <= '0;
    cfg_pwdata           <= '0;
    stall_free = 1'b0;
    in_gaps_on = 1'b1;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words at reset settings (theta 26/256, K 4)
    // ack before any load: reported delay beats the zero delay
    send_word(mk_word(1'b1, 1'b1, 32'd5, 32'd0, 32'd10, 32'd7), dec);
    send_word(mk_word(1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd0), dec);
    // zero against zero stays put
    send_word(mk_word(1'b1, 1'b1, 32'd1, 32'd0, 32'd1, 32'd0), dec);
    // load all ones, then the widest window with all-ones fields
    send_word(mk_word(1'b0, 1'b1, '1, '1, '1, '1), dec);
    send_word(mk_word(1'b1, 1'b1, '1, 32'd0, '1, '1), dec);
    // reported zero means infinite rate: increase lands on zero
    send_word(mk_word(1'b1, 1'b1, 32'd5, 32'd0, 32'd10, 32'd0), dec);
    send_word(mk_word(1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd1000), dec);
    // packet filter: no ack flag, ack at floor, ack at top, past top, empty window
    send_word(mk_word(1'b1, 1'b0, 32'd5, 32'd0, 32'd10, 32'd5), dec);
    send_word(mk_word(1'b1, 1'b1, 32'd3, 32'd3, 32'd10, 32'd5), dec);
    send_word(mk_word(1'b1, 1'b1, 32'd10, 32'd3, 32'd10, 32'd1000), dec);
    send_word(mk_word(1'b1, 1'b1, 32'd11, 32'd3, 32'd10, 32'd5), dec);
    send_word(mk_word(1'b1, 1'b1, 32'd4, 32'd3, 32'd3, 32'd5), dec);
    // window wrapping through zero with a rate decrease, then a rate increase
    send_word(mk_word(1'b1, 1'b1, 32'd5, 32'hFFFF_FFF0, 32'd10, 32'd2000), dec);
    send_word(mk_word(1'b1, 1'b1, 32'd2, 32'd0, 32'd9, 32'd1000), dec);
    // exactly at the threshold stays, one above increases
    send_word(mk_word(1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd282), dec);
    send_word(mk_word(1'b1, 1'b1, 32'd1, 32'd0, 32'd1, 32'd256), dec);
    send_word(mk_word(1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd283), dec);
    send_word(mk_word(1'b1, 1'b1, 32'd1, 32'd0, 32'd1, 32'd256), dec);
    // largest blend operands
    send_word(mk_word(1'b0, 1'b0, 32'd0, 32'd0, 32'd0, '1), dec);
    send_word(mk_word(1'b1, 1'b1, 32'd1, 32'd0, 32'd1, 32'd1), dec);
    // full-span window whose floor is all ones
    send_word(mk_word(1'b1, 1'b1, 32'd0, '1, 32'hFFFF_FFFE, '1), dec);
    // divisor zero acts as one: increase jumps to the reported delay
    settle();
    write_reg(REG_KDIV, 8'd0);
    send_word(mk_word(1'b0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd1000), dec);
    send_word(mk_word(1'b1, 1'b1, 32'd1, 32'd0, 32'd1, 32'd100), dec);

    // random phases across register extremes, one phase with no idling
    run_phase(8'd0,   8'd1,   250, 1'b0);
    run_phase(8'd255, 8'd255, 250, 1'b0);
    run_phase(8'd26,  8'd4,   250, 1'b1);
    run_phase(8'd0,   8'd0,   250, 1'b0);
    run_phase(8'd255, 8'd1,   250, 1'b0);
    run_phase(8'd128, 8'd2,   250, 1'b0);
    run_phase(8'($urandom), 8'($urandom_range(1, 255)), 250, 1'b0);
    run_phase(8'($urandom), 8'($urandom_range(1, 255)), 250, 1'b0);

    // drain, then watch for stray words
    settle();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/apsdc_pkg.sv
hdl/apsdc_in_if.sv
hdl/apsdc_out_if.sv
hdl/ack_paced_send_delay_control_top.sv
dv/ack_paced_send_delay_control_top_tb.sv
